>>> design/stc_pkg.sv
// ============================================================================
// stc_pkg - shared types and constants for the scope trigger capture block
// Field widths, payload structs, register indexes and reset values.
// ============================================================================
package stc_pkg;

  localparam int RAW_W    = 12;
  localparam int ROW_W    = 10;
  localparam int INDEX_W  = 9;
  localparam int RISE_W   = 4;
  localparam int PROD_W   = RAW_W + ROW_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROW_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_CHECK_COUNT = 2'd1;

  // Reset values
  localparam logic [ROW_W-1:0]  DISPLAY_HEIGHT_RESET   = 10'd240;
  localparam logic [RISE_W-1:0] RISE_CHECK_COUNT_RESET = 4'd7;

  localparam int CAPTURE_LENGTH_DEFAULT = 320;

  typedef struct packed {
    logic [RAW_W-1:0] signal_raw;
    logic [RAW_W-1:0] level_raw;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   sample_row;
    logic [INDEX_W-1:0] sample_index;
    logic               frame_last;
  } out_item_t;

endpackage

>>> design/scope_trigger_capture_top.sv
// ============================================================================
// scope_trigger_capture_top - level-triggered capture of a sampled signal
// Scales signal and trigger readings to screen rows, starts a frame on an
// exact level match, drops samples below the level in the rise window and
// emits each kept sample with its frame position and a last mark.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall   | signal_raw, level_raw
//   out     | output    | out_valid/out_stall | sample_row, sample_index,
//           |           |                     | frame_last
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; a kept item passes
// the product register, then the result register, on its way from in to out.
// The frame counter update sits in the result stage, so each item sees the
// counter left by the one before it with no bubble.
// rst is synchronous, active high: counter, trigger level, valids and
// configuration registers return to their reset values.
// A stall on out holds the result register; the product stage then holds too
// and in_stall rises only when both stages are full.
// ============================================================================
module scope_trigger_capture_top #(
  parameter int CAPTURE_LENGTH = stc_pkg::CAPTURE_LENGTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  stc_pkg::in_item_t              in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output stc_pkg::out_item_t             out_data,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stc_pkg::*;

  // Frame length as a counter-width constant
  localparam logic [INDEX_W-1:0] CAP_LEN  = INDEX_W'(CAPTURE_LENGTH);
  localparam logic [INDEX_W-1:0] CAP_LAST = INDEX_W'(CAPTURE_LENGTH - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]  display_height;
  logic [RISE_W-1:0] rise_check_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_height   <= DISPLAY_HEIGHT_RESET;
      rise_check_count <= RISE_CHECK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_HEIGHT:   display_height   <= cfg_data;
        REG_RISE_CHECK_COUNT: rise_check_count <= cfg_data[RISE_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake between stages
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_free;   // result register can take a new value this cycle
  logic advance;    // product stage hands its item to the result stage
  logic in_take;    // transfer on the input channel

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Stage 1: multiply both readings by the display height
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] sig_prod;
  logic [PROD_W-1:0] lvl_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sig_prod <= PROD_W'(in_data.signal_raw) * PROD_W'(display_height);
      lvl_prod <= PROD_W'(in_data.level_raw) * PROD_W'(display_height);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by full scale, trigger and rise check, frame counter
  // --------------------------------------------------------------------------
  // Divide by 4095 = 2^12 - 1 as (x + (x >> 12) + 1) >> 12, exact for every
  // product of a 12-bit reading and a 10-bit height.
  logic [PROD_W:0]    sig_sum;
  logic [PROD_W:0]    lvl_sum;
  logic [ROW_W-1:0]   sig_row;
  logic [ROW_W-1:0]   lvl_row;

  logic [INDEX_W-1:0] captured_count;
  logic [INDEX_W-1:0] captured_count_next;
  logic [ROW_W-1:0]   trigger_level;
  logic [ROW_W-1:0]   trigger_level_next;
  logic [INDEX_W-1:0] count_inc;
  logic               idle;
  logic               in_rise_window;
  logic               keep;
  logic               last;

  assign sig_sum = (PROD_W+1)'(sig_prod) + (PROD_W+1)'(sig_prod >> RAW_W) + 1'b1;
  assign lvl_sum = (PROD_W+1)'(lvl_prod) + (PROD_W+1)'(lvl_prod >> RAW_W) + 1'b1;
  assign sig_row = sig_sum[RAW_W +: ROW_W];
  assign lvl_row = lvl_sum[RAW_W +: ROW_W];

  assign idle           = (captured_count == '0);
  assign in_rise_window = !idle && (captured_count <= INDEX_W'(rise_check_count));
  assign count_inc      = captured_count + 1'b1;
  assign last           = (count_inc >= CAP_LEN);

  always_comb begin
    keep                = 1'b0;
    trigger_level_next  = trigger_level;
    captured_count_next = captured_count;
    if (advance) begin
      if (idle) begin
        // Latch the level on every idle sample, matched or not
        trigger_level_next = lvl_row;
        keep               = (sig_row == lvl_row);
      end else if (in_rise_window) begin
        keep = (sig_row >= trigger_level);
      end else begin
        keep = 1'b1;
      end
      if (keep) begin
        captured_count_next = last ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      captured_count <= '0;
      trigger_level  <= '0;
      out_valid      <= 1'b0;
    end else begin
      captured_count <= captured_count_next;
      trigger_level  <= trigger_level_next;
      if (keep) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        // result taken (or none held) and nothing new: clear
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      out_data.sample_row   <= sig_row;
      out_data.sample_index <= captured_count;
      out_data.frame_last   <= last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    captured_count < CAP_LEN)
    else $error("frame counter passed the capture length");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.frame_last == (out_data.sample_index == CAP_LAST)))
    else $error("last mark does not match the final frame position");

  a_first_on_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.sample_index == '0) |->
      (out_data.sample_row == trigger_level))
    else $error("frame start sample differs from the latched level");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while a stage was free");

  a_counter_moves_on_emit: assert property (@(posedge clk) disable iff (rst)
    (captured_count != $past(captured_count)) && !$past(rst) |-> $past(keep))
    else $error("frame counter changed without an emitted sample");

endmodule
